>>> hw/rtl/e2c_pkg.sv
// shared types, constants and calendar tables for the epoch-to-calendar block
`default_nettype none

package e2c_pkg;

  localparam int SECONDS_WIDTH_DEF = 36;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int EPOCH_YEAR    = 1970;
  localparam int DAYS_LEAP     = 366;
  localparam int DAYS_NORMAL   = 365;

  localparam int YEAR_OUT_W   = 13;
  localparam int MONTH_OUT_W  = 4;
  localparam int DAY_OUT_W    = 5;
  localparam int HOUR_OUT_W   = 5;
  localparam int MINUTE_OUT_W = 6;

  localparam int MONTHS     = 12;
  localparam int MONTH_FEB  = 1;

  typedef logic [4:0] mlen_t;

  localparam mlen_t MONTH_LEN [MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic                    has_date;
    logic [YEAR_OUT_W-1:0]   year;
    logic [MONTH_OUT_W-1:0]  month;
    logic [DAY_OUT_W-1:0]    day;
    logic [HOUR_OUT_W-1:0]   hour;
    logic [MINUTE_OUT_W-1:0] minute;
  } e2c_result_t;

  // days in a month, zero-based month index
  function automatic mlen_t month_days(logic [MONTH_OUT_W-1:0] mon, logic leap);
    mlen_t len;
    len = 5'd31;
    if (mon < MONTH_OUT_W'(MONTHS)) begin
      len = MONTH_LEN[mon];
    end
    if (mon == MONTH_OUT_W'(MONTH_FEB) && leap) begin
      len = len + 5'd1;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/e2c_subunit.sv
// shared compare-and-subtract unit
`default_nettype none

module e2c_subunit #(
  parameter int Width = 18
) (
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  output logic      [Width-1:0] diff_o,
  output logic                  ge_o
);

  logic [Width:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[Width-1:0];
  assign ge_o   = ~full[Width];

endmodule

`default_nettype wire

>>> hw/rtl/e2c_core.sv
// sequencer and working registers: year, month, day, hour and minute walks on the seconds
`default_nettype none

module e2c_core
  import e2c_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [SECONDS_WIDTH-1:0] seconds_i,
  input  wire logic                     ack_i,
  output logic                          idle_o,
  output logic                          done_o,
  output e2c_result_t                   result_o
);

  localparam int UNIT_W = SECONDS_WIDTH;
  // a year is more than 2^24 seconds, so the year count stays below 2^(SECONDS_WIDTH-24)
  localparam int YEAR_W = (SECONDS_WIDTH - 24 > YEAR_OUT_W) ? SECONDS_WIDTH - 24 : YEAR_OUT_W;

  localparam logic [UNIT_W-1:0] SECS_YEAR_LEAP   = UNIT_W'(DAYS_LEAP * SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_YEAR_NORMAL = UNIT_W'(DAYS_NORMAL * SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_MON_28      = UNIT_W'(28 * SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_MON_29      = UNIT_W'(29 * SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_MON_30      = UNIT_W'(30 * SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_MON_31      = UNIT_W'(31 * SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_DAY         = UNIT_W'(SECS_PER_DAY);
  localparam logic [UNIT_W-1:0] SECS_HOUR        = UNIT_W'(SECS_PER_HOUR);
  localparam logic [UNIT_W-1:0] SECS_MIN         = UNIT_W'(SECS_PER_MIN);

  localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_YEAR  = 3'd1;
  localparam logic [2:0] ST_MONTH = 3'd2;
  localparam logic [2:0] ST_DAY   = 3'd3;
  localparam logic [2:0] ST_HOUR  = 3'd4;
  localparam logic [2:0] ST_MIN   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [UNIT_W-1:0]        rem_q, rem_d;
  logic [YEAR_W-1:0]        year_q, year_d;
  logic [1:0]               m4_q, m4_d;
  logic [6:0]               m100_q, m100_d;
  logic [8:0]               m400_q, m400_d;
  logic [MONTH_OUT_W-1:0]   month_q, month_d;
  logic [DAY_OUT_W-1:0]     day_q, day_d;
  logic [HOUR_OUT_W-1:0]    hour_q, hour_d;
  logic [MINUTE_OUT_W-1:0]  min_q, min_d;
  logic                     has_q, has_d;

  logic [UNIT_W-1:0] op_a, op_b, diff;
  logic              ge;
  logic              leap;
  mlen_t             mlen;
  logic [UNIT_W-1:0] mon_secs;

  e2c_subunit #(.Width(UNIT_W)) u_sub (
    .a_i    (op_a),
    .b_i    (op_b),
    .diff_o (diff),
    .ge_o   (ge)
  );

  assign leap = (m4_q == 2'd0 && m100_q != 7'd0) || (m400_q == 9'd0);
  assign mlen = month_days(month_q, leap);
  assign op_a = rem_q;

  // month length in seconds
  always_comb begin
    case (mlen)
      5'd28: mon_secs = SECS_MON_28;
      5'd29: mon_secs = SECS_MON_29;
      5'd30: mon_secs = SECS_MON_30;
      default: mon_secs = SECS_MON_31;
    endcase
  end

  // subtrahend select for the shared unit
  always_comb begin
    case (state_q)
      ST_YEAR: begin
        op_b = leap ? SECS_YEAR_LEAP : SECS_YEAR_NORMAL;
      end
      ST_MONTH: begin
        op_b = mon_secs;
      end
      ST_DAY: begin
        op_b = SECS_DAY;
      end
      ST_HOUR: begin
        op_b = SECS_HOUR;
      end
      ST_MIN: begin
        op_b = SECS_MIN;
      end
      default: begin
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    year_d  = year_q;
    m4_d    = m4_q;
    m100_d  = m100_q;
    m400_d  = m400_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    has_d   = has_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rem_d   = seconds_i;
          year_d  = YEAR_W'(EPOCH_YEAR);
          m4_d    = EPOCH_MOD4;
          m100_d  = EPOCH_MOD100;
          m400_d  = EPOCH_MOD400;
          month_d = '0;
          day_d   = '0;
          hour_d  = '0;
          min_d   = '0;
          has_d   = (seconds_i != '0);
          state_d = (seconds_i != '0) ? ST_YEAR : ST_DONE;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          rem_d  = diff;
          year_d = year_q + YEAR_W'(1);
          m4_d   = m4_q + 2'd1;
          m100_d = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
          m400_d = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
        end else begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ge) begin
          rem_d   = diff;
          month_d = month_q + MONTH_OUT_W'(1);
        end else begin
          state_d = ST_DAY;
        end
      end
      ST_DAY: begin
        if (ge) begin
          rem_d = diff;
          day_d = day_q + DAY_OUT_W'(1);
        end else begin
          state_d = ST_HOUR;
        end
      end
      ST_HOUR: begin
        if (ge) begin
          rem_d  = diff;
          hour_d = hour_q + HOUR_OUT_W'(1);
        end else begin
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        if (ge) begin
          rem_d = diff;
          min_d = min_q + MINUTE_OUT_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    year_q  <= year_d;
    m4_q    <= m4_d;
    m100_q  <= m100_d;
    m400_q  <= m400_d;
    month_q <= month_d;
    day_q   <= day_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    has_q   <= has_d;
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  // no-date transactions report all zeros
  always_comb begin
    result_o          = '0;
    result_o.has_date = has_q;
    if (has_q) begin
      result_o.year   = year_q[YEAR_OUT_W-1:0];
      result_o.month  = month_q + MONTH_OUT_W'(1);
      result_o.day    = day_q + DAY_OUT_W'(1);
      result_o.hour   = hour_q;
      result_o.minute = min_q;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/epoch_seconds_to_calendar_top.sv
// Converts seconds since 1970-01-01 00:00 UTC into year, month, day, hour and minute.
// Input channel: in_valid_i / in_ready_o carry seconds_i; zero means no date is known
// and the result then has has_date_o low with every other field zero.
// Output channel: out_valid_o / out_ready_i carry one result per input transaction.
// One transaction at a time: in_ready_o is high only while the sequencer is idle.
// Operation: the shared subtractor walks whole years after 1970, then whole months,
// whole days, hours and minutes off the seconds, each walk ending on the first failed
// compare, and then the result is loaded into the output register. With the default
// 36-bit input the year walk dominates.
// A zero input skips the walks and goes straight to loading the output register.
// The result sits in an output register; a new transaction is taken once the
// sequencer has handed its result to that register, even while it waits to be taken.
// If the receiver stalls with a result already held, the next result waits in the
// sequencer until the register frees, and in_ready_o stays low meanwhile.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops out_valid_o.
`default_nettype none

module epoch_seconds_to_calendar_top
  import e2c_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [SECONDS_WIDTH-1:0] seconds_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          has_date_o,
  output logic [YEAR_OUT_W-1:0]         year_o,
  output logic [MONTH_OUT_W-1:0]        month_o,
  output logic [DAY_OUT_W-1:0]          day_o,
  output logic [HOUR_OUT_W-1:0]         hour_o,
  output logic [MINUTE_OUT_W-1:0]       minute_o
);

  logic        core_idle, core_done, core_ack, start;
  e2c_result_t core_res;
  e2c_result_t out_q;
  logic        out_valid_q, out_valid_d;

  assign in_ready_o = core_idle;
  assign start      = in_valid_i & core_idle;
  assign core_ack   = core_done & (~out_valid_q | out_ready_i);

  e2c_core #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .seconds_i (seconds_i),
    .ack_i     (core_ack),
    .idle_o    (core_idle),
    .done_o    (core_done),
    .result_o  (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_ack) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ack) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign has_date_o  = out_q.has_date;
  assign year_o      = out_q.year;
  assign month_o     = out_q.month;
  assign day_o       = out_q.day;
  assign hour_o      = out_q.hour;
  assign minute_o    = out_q.minute;

endmodule

`default_nettype wire

>>> hw/rtl/e2c_checker.sv
// port-level checks for the epoch-to-calendar block, bound to the top level
`default_nettype none

module e2c_checker
  import e2c_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic [SECONDS_WIDTH-1:0] seconds_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic                     has_date_o,
  input wire logic [YEAR_OUT_W-1:0]    year_o,
  input wire logic [MONTH_OUT_W-1:0]   month_o,
  input wire logic [DAY_OUT_W-1:0]     day_o,
  input wire logic [HOUR_OUT_W-1:0]    hour_o,
  input wire logic [MINUTE_OUT_W-1:0]  minute_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(has_date_o) && $stable(year_o)
      && $stable(month_o) && $stable(day_o) && $stable(hour_o) && $stable(minute_o))
    else $error("result changed while stalled");

  // one transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a transaction while busy");

  // no date means all fields zero
  a_no_date_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_date_o |-> year_o == '0 && month_o == '0 && day_o == '0
      && hour_o == '0 && minute_o == '0)
    else $error("no-date result carries nonzero fields");

  // a dated result has month 1 to 12, day at least 1, hour up to 23 and minute up to 59
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_date_o |-> month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1
      && hour_o <= 5'd23 && minute_o <= 6'd59)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_top e2c_checker #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_e2c_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .seconds_i   (seconds_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .has_date_o  (has_date_o),
  .year_o      (year_o),
  .month_o     (month_o),
  .day_o       (day_o),
  .hour_o      (hour_o),
  .minute_o    (minute_o)
);

`default_nettype wire

>>> test/epoch_seconds_to_calendar_top_tb.sv
// testbench for the epoch seconds to calendar date converter
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top_tb;
  import e2c_pkg::*;

  localparam int SECS_W         = SECONDS_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int LONG_HOLD      = 3000;
  // drain long enough to outlast the slowest conversion and catch stray results
  localparam int DRAIN_CYCLES   = 2400;

  localparam int unsigned DAYS_IN_MONTH [MONTHS] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  localparam logic [SECS_W-1:0] CORNER_SECONDS [24] = '{
    36'd0,            // no date
    36'd1,
    36'd59,
    36'd60,
    36'd3599,
    36'd3600,
    36'd86399,
    36'd86400,
    36'd31535999,     // last second of 1970
    36'd31536000,
    36'd68169600,     // 1972-02-29
    36'd68255999,
    36'd68256000,     // 1972-03-01
    36'd94607999,     // 1972-12-30 23:59:59, leap year 1972
    36'd951782400,    // 2000-02-29, century leap year
    36'd4107542399,   // 2100-02-28, century but not leap
    36'd4107542400,
    36'd4294967295,
    36'd4294967296,
    36'd13574563200,  // 2400-02-29
    36'd34359738368,
    36'hAAAAAAAAA,
    36'h555555555,
    36'hFFFFFFFFF
  };

  typedef struct {
    logic [SECS_W-1:0] secs;
    e2c_result_t       date;
  } pending_date_t;

  logic                      clk_i      = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic [SECS_W-1:0]         seconds    = '0;
  logic                      out_ready  = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic                      has_date_o;
  logic [YEAR_OUT_W-1:0]     year_o;
  logic [MONTH_OUT_W-1:0]    month_o;
  logic [DAY_OUT_W-1:0]      day_o;
  logic [HOUR_OUT_W-1:0]     hour_o;
  logic [MINUTE_OUT_W-1:0]   minute_o;

  pending_date_t pending_dates [$];
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  int            hold_off       = 0;
  bit            steady         = 1'b0;

  always #1 clk_i = ~clk_i;

  epoch_seconds_to_calendar_top #(
    .SECONDS_WIDTH(SECS_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .seconds_i  (seconds),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .has_date_o (has_date_o),
    .year_o     (year_o),
    .month_o    (month_o),
    .day_o      (day_o),
    .hour_o     (hour_o),
    .minute_o   (minute_o)
  );

  function automatic bit leap_year(int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // walk whole years, then whole months, off the day count
  function automatic e2c_result_t calendar_of(logic [SECS_W-1:0] secs);
    e2c_result_t     r;
    longint unsigned days;
    longint unsigned rem;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     mlen;
    bit              leap;
    r = '0;
    if (secs == '0) begin
      return r;
    end
    days = longint'(secs) / SECS_PER_DAY;
    rem  = longint'(secs) % SECS_PER_DAY;
    yr   = EPOCH_YEAR;
    while (days >= (leap_year(yr) ? DAYS_LEAP : DAYS_NORMAL)) begin
      days -= leap_year(yr) ? DAYS_LEAP : DAYS_NORMAL;
      yr++;
    end
    leap = leap_year(yr);
    mon  = 0;
    while (mon < MONTHS) begin
      mlen = DAYS_IN_MONTH[mon] + ((mon == MONTH_FEB && leap) ? 1 : 0);
      if (days < mlen) begin
        break;
      end
      days -= mlen;
      mon++;
    end
    r.has_date = 1'b1;
    r.year     = YEAR_OUT_W'(yr);
    r.month    = MONTH_OUT_W'(mon + 1);
    r.day      = DAY_OUT_W'(days + 1);
    r.hour     = HOUR_OUT_W'(rem / SECS_PER_HOUR);
    r.minute   = MINUTE_OUT_W'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
    return r;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return $urandom_range(1, 3);
    end else if (r < 9) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // called and returns at a rising edge; returns at the edge that takes the transaction
  task automatic offer_seconds(input logic [SECS_W-1:0] secs);
    int            gap;
    pending_date_t entry;
    gap = 0;
    if (!steady && $urandom_range(0, 1) != 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    seconds  <= secs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    entry.secs = secs;
    entry.date = calendar_of(secs);
    pending_dates.push_back(entry);
  endtask

  task automatic test_corner_dates();
    foreach (CORNER_SECONDS[i]) begin
      offer_seconds(CORNER_SECONDS[i]);
    end
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) begin
        offer_seconds('0);
      end else begin
        offer_seconds(SECS_W'($urandom));
      end
    end
  endtask

  task automatic test_wide_dates(input int count);
    repeat (count) begin
      offer_seconds({4'($urandom_range(0, 15)), 32'($urandom)});
    end
  endtask

  // seconds just around the start of a random month of a random year
  task automatic test_calendar_boundaries(input int count);
    int unsigned       yr;
    int unsigned       y;
    int unsigned       mon;
    int unsigned       m;
    longint unsigned   days;
    logic [SECS_W-1:0] secs;
    repeat (count) begin
      yr   = $urandom_range(1971, 4146);
      days = 0;
      for (y = EPOCH_YEAR; y < yr; y++) begin
        days += leap_year(y) ? DAYS_LEAP : DAYS_NORMAL;
      end
      mon = $urandom_range(0, MONTHS - 1);
      for (m = 0; m < mon; m++) begin
        days += DAYS_IN_MONTH[m] + ((m == MONTH_FEB && leap_year(yr)) ? 1 : 0);
      end
      secs = SECS_W'(days * SECS_PER_DAY);
      if ($urandom_range(0, 1) != 0) begin
        secs = secs - SECS_W'($urandom_range(1, 120));
      end else begin
        secs = secs + SECS_W'($urandom_range(0, 120));
      end
      offer_seconds(secs);
    end
  endtask

  // receiver holds off while transactions keep coming, so the input backs up
  task automatic test_output_stall();
    hold_off = LONG_HOLD;
    steady   = 1'b1;
    repeat (8) begin
      offer_seconds(SECS_W'($urandom_range(1, 200000000)));
    end
    steady = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    test_random_dates(6);
  endtask

  task automatic test_no_idle(input int count);
    steady = 1'b1;
    test_random_dates(count);
    steady = 1'b0;
  endtask

  initial begin : receiver
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off > 0) begin
        n        = hold_off;
        hold_off = 0;
      end else if (steady || $urandom_range(0, 2) != 0) begin
        n = 0;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    e2c_result_t   got;
    pending_date_t want;
    if (rst_n && out_valid_o && out_ready) begin
      got = {has_date_o, year_o, month_o, day_o, hour_o, minute_o};
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending, year %0d", got.year));
      end else begin
        want = pending_dates.pop_front();
        if (got.has_date != want.date.has_date)
          report_mismatch($sformatf("secs %0d has_date: got %0d expected %0d",
                                    want.secs, got.has_date, want.date.has_date));
        if (got.year != want.date.year)
          report_mismatch($sformatf("secs %0d year: got %0d expected %0d",
                                    want.secs, got.year, want.date.year));
        if (got.month != want.date.month)
          report_mismatch($sformatf("secs %0d month: got %0d expected %0d",
                                    want.secs, got.month, want.date.month));
        if (got.day != want.date.day)
          report_mismatch($sformatf("secs %0d day: got %0d expected %0d",
                                    want.secs, got.day, want.date.day));
        if (got.hour != want.date.hour)
          report_mismatch($sformatf("secs %0d hour: got %0d expected %0d",
                                    want.secs, got.hour, want.date.hour));
        if (got.minute != want.date.minute)
          report_mismatch($sformatf("secs %0d minute: got %0d expected %0d",
                                    want.secs, got.minute, want.date.minute));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_corner_dates();
    test_random_dates(140);
    test_output_stall();
    test_pause_until_empty();
    test_no_idle(20);
    test_wide_dates(40);
    test_calendar_boundaries(24);
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
